/* rtl/hffa_pkg.sv */
// hffa_pkg: shared types, codes and constants of the hemicube form factor accumulate unit
// no dependencies; used by every module under rtl except hffa_ram
package hffa_pkg;

  localparam int MAX_HALF_RES     = 64;
  localparam int MAX_ELEMENTS     = 4096;
  localparam int FACTOR_FRAC_BITS = 32;
  localparam int SUM_W            = FACTOR_FRAC_BITS + 2;
  localparam int ID_W             = 24;
  localparam int TBL_AW_MAX       = 16;
  localparam int SUM_AW_MAX       = 16;
  localparam int CMD_FIFO_DEPTH   = 2;

  localparam logic [ID_W-1:0] BG_WIDE   = 24'hFFFFFF;
  localparam logic [ID_W-1:0] BG_NARROW = 24'h00FFFF;

  localparam logic [6:0] HALF_RES_RESET = 7'd32;
  localparam logic       WIDE_IDS_RESET = 1'b1;

  localparam logic CFG_HALF_RES = 1'b0;
  localparam logic CFG_WIDE_IDS = 1'b1;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_WR_TOP    = 3'd1,
    OP_WR_SIDE   = 3'd2,
    OP_ACCUM     = 3'd3,
    OP_READ      = 3'd4
  } hffa_op_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_SAT     = 2'd3
  } hffa_status_e;

  typedef enum logic [2:0] {
    K_CLEAR,
    K_WR_TOP,
    K_WR_SIDE,
    K_ACC,
    K_READ,
    K_NOP
  } hffa_kind_e;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_EXEC,
    BK_CLEAR
  } hffa_bk_state_e;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic [6:0]                  row;
    logic [6:0]                  col;
    logic                        face_kind;
    logic [ID_W-1:0]             item_id;
    logic [FACTOR_FRAC_BITS-1:0] factor_value;
  } hffa_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] form_factor;
    logic [1:0]       status;
  } hffa_out_t;

  typedef struct packed {
    hffa_kind_e                  kind;
    hffa_status_e                status;
    logic                        face_kind;
    logic [TBL_AW_MAX-1:0]       tbl_addr;
    logic [SUM_AW_MAX-1:0]       sum_addr;
    logic [FACTOR_FRAC_BITS-1:0] value;
  } hffa_cmd_t;

endpackage

/* rtl/hffa_ram.sv */
// hffa_ram: generic single write port, single read port ram with registered read
// no dependencies
module hffa_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/hffa_front.sv */
// hffa_front: decodes and classifies one command word, folds pixel coordinates
// depends on hffa_pkg
module hffa_front #(
  parameter int MaxHalfRes  = hffa_pkg::MAX_HALF_RES,
  parameter int MaxElements = hffa_pkg::MAX_ELEMENTS
) (
  input  hffa_pkg::hffa_in_t  in_i,
  input  logic [6:0]          half_res_i,
  input  logic                wide_ids_i,
  output hffa_pkg::hffa_cmd_t cmd_o
);

  localparam logic [8:0]  HalfResLim = 9'(MaxHalfRes);
  localparam logic [15:0] RowStride  = 16'(MaxHalfRes);
  localparam logic [24:0] ElemLim    = 25'(MaxElements);

  logic [6:0]  h;
  logic [7:0]  h2;
  logic [7:0]  row_w;
  logic [7:0]  col_w;
  logic [6:0]  frow;
  logic [6:0]  fcol;
  logic        off_face;
  logic        upper_half;
  logic        is_bg;
  logic        id_oor;
  logic        tbl_oor;
  logic [23:0] bg_id;
  logic [15:0] fold_addr;
  logic [15:0] raw_addr;

  always_comb begin
    if (half_res_i == 7'd0) begin
      h = 7'd1;
    end else if ({2'b00, half_res_i} > HalfResLim) begin
      h = 7'(MaxHalfRes);
    end else begin
      h = half_res_i;
    end
  end

  assign h2         = {h, 1'b0};
  assign row_w      = {1'b0, in_i.row};
  assign col_w      = {1'b0, in_i.col};
  assign off_face   = (row_w >= h2) || (col_w >= h2);
  assign upper_half = in_i.face_kind && (in_i.row < h);
  assign bg_id      = wide_ids_i ? hffa_pkg::BG_WIDE : hffa_pkg::BG_NARROW;
  assign is_bg      = (in_i.item_id == bg_id);
  assign id_oor     = ({1'b0, in_i.item_id} >= ElemLim);
  assign tbl_oor    = ({2'b00, in_i.row} >= HalfResLim) || ({2'b00, in_i.col} >= HalfResLim);
  assign frow       = (in_i.row < h) ? in_i.row : 7'(h2 - 8'd1 - row_w);
  assign fcol       = (in_i.col < h) ? in_i.col : 7'(h2 - 8'd1 - col_w);
  assign fold_addr  = 16'(16'(frow) * RowStride + 16'(fcol));
  assign raw_addr   = 16'(16'(in_i.row) * RowStride + 16'(in_i.col));

  always_comb begin
    cmd_o.kind      = hffa_pkg::K_NOP;
    cmd_o.status    = hffa_pkg::STAT_DONE;
    cmd_o.face_kind = in_i.face_kind;
    cmd_o.tbl_addr  = raw_addr;
    cmd_o.sum_addr  = in_i.item_id[hffa_pkg::SUM_AW_MAX-1:0];
    cmd_o.value     = in_i.factor_value;
    case (hffa_pkg::hffa_op_e'(in_i.opcode))
      hffa_pkg::OP_CLEAR: begin
        cmd_o.kind = hffa_pkg::K_CLEAR;
      end
      hffa_pkg::OP_WR_TOP, hffa_pkg::OP_WR_SIDE: begin
        if (tbl_oor) begin
          cmd_o.status = hffa_pkg::STAT_RANGE;
        end else if (in_i.opcode == hffa_pkg::OP_WR_TOP) begin
          cmd_o.kind = hffa_pkg::K_WR_TOP;
        end else begin
          cmd_o.kind = hffa_pkg::K_WR_SIDE;
        end
      end
      hffa_pkg::OP_ACCUM: begin
        cmd_o.tbl_addr = fold_addr;
        if (off_face) begin
          cmd_o.status = hffa_pkg::STAT_RANGE;
        end else if (upper_half || is_bg) begin
          cmd_o.status = hffa_pkg::STAT_IGNORED;
        end else if (id_oor) begin
          cmd_o.status = hffa_pkg::STAT_RANGE;
        end else begin
          cmd_o.kind = hffa_pkg::K_ACC;
        end
      end
      hffa_pkg::OP_READ: begin
        if (id_oor) begin
          cmd_o.status = hffa_pkg::STAT_RANGE;
        end else begin
          cmd_o.kind = hffa_pkg::K_READ;
        end
      end
      default: begin
        cmd_o.status = hffa_pkg::STAT_IGNORED;
      end
    endcase
  end

endmodule

/* rtl/hffa_fifo.sv */
// hffa_fifo: short command queue between the decode front and the execute back
// depends on hffa_pkg
module hffa_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hffa_pkg::hffa_cmd_t data_i,
  input  logic                pop_i,
  output hffa_pkg::hffa_cmd_t data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int Depth = hffa_pkg::CMD_FIFO_DEPTH;
  localparam int Pw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Cw    = $clog2(Depth + 1);

  hffa_pkg::hffa_cmd_t slot_q [Depth];
  logic [Pw-1:0] wptr_q, wptr_d;
  logic [Pw-1:0] rptr_q, rptr_d;
  logic [Cw-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Cw'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == Pw'(Depth - 1)) ? '0 : Pw'(wptr_q + 1'b1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == Pw'(Depth - 1)) ? '0 : Pw'(rptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = Cw'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = Cw'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/hffa_back.sv */
// hffa_back: executes queued commands against the factor tables and the sum memory
// depends on hffa_pkg and hffa_ram
module hffa_back #(
  parameter int MaxHalfRes  = hffa_pkg::MAX_HALF_RES,
  parameter int MaxElements = hffa_pkg::MAX_ELEMENTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hffa_pkg::hffa_cmd_t cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output logic                init_o,
  output logic                done_o,
  output hffa_pkg::hffa_out_t result_o
);

  localparam int TblDepth = MaxHalfRes * MaxHalfRes;
  localparam int TblAw    = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam int SumAw    = $clog2(MaxElements);
  localparam int SumW     = hffa_pkg::SUM_W;
  localparam int FacW     = hffa_pkg::FACTOR_FRAC_BITS;
  localparam logic [SumAw-1:0] LastIdx = SumAw'(MaxElements - 1);

  hffa_pkg::hffa_bk_state_e state_q, state_d;
  logic [SumAw-1:0]    cnt_q, cnt_d;
  hffa_pkg::hffa_cmd_t cur_q;
  logic                done_q, done_d;
  hffa_pkg::hffa_out_t res_q, res_d;

  logic             top_we;
  logic             side_we;
  logic [FacW-1:0]  top_rd;
  logic [FacW-1:0]  side_rd;
  logic             sum_we;
  logic [SumAw-1:0] sum_waddr;
  logic [SumW-1:0]  sum_wdata;
  logic [SumW-1:0]  sum_rd;
  logic [FacW-1:0]  factor;
  logic [SumW:0]    sum_add;
  logic             last;

  assign last    = (cnt_q == LastIdx);
  assign factor  = cur_q.face_kind ? side_rd : top_rd;
  assign sum_add = {1'b0, sum_rd} + (SumW + 1)'(factor);

  always_comb begin
    state_d = state_q;
    case (state_q)
      hffa_pkg::BK_INIT, hffa_pkg::BK_CLEAR: begin
        if (last) begin
          state_d = hffa_pkg::BK_IDLE;
        end
      end
      hffa_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == hffa_pkg::K_CLEAR) ? hffa_pkg::BK_CLEAR : hffa_pkg::BK_EXEC;
        end
      end
      hffa_pkg::BK_EXEC: begin
        state_d = hffa_pkg::BK_IDLE;
      end
      default: begin
        state_d = hffa_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    top_we    = 1'b0;
    side_we   = 1'b0;
    sum_we    = 1'b0;
    sum_waddr = cur_q.sum_addr[SumAw-1:0];
    sum_wdata = sum_add[SumW-1:0];
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    res_d     = '0;
    init_o    = (state_q == hffa_pkg::BK_INIT);
    case (state_q)
      hffa_pkg::BK_INIT, hffa_pkg::BK_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = cnt_q;
        sum_wdata = '0;
        cnt_d     = SumAw'(cnt_q + 1'b1);
        if (last && state_q == hffa_pkg::BK_CLEAR) begin
          done_d       = 1'b1;
          res_d.status = hffa_pkg::STAT_DONE;
        end
      end
      hffa_pkg::BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        top_we    = cmd_valid_i && (cmd_i.kind == hffa_pkg::K_WR_TOP);
        side_we   = cmd_valid_i && (cmd_i.kind == hffa_pkg::K_WR_SIDE);
        cnt_d     = '0;
      end
      hffa_pkg::BK_EXEC: begin
        done_d = 1'b1;
        case (cur_q.kind)
          hffa_pkg::K_ACC: begin
            sum_we = 1'b1;
            if (sum_add[SumW]) begin
              sum_wdata    = '1;
              res_d.status = hffa_pkg::STAT_SAT;
            end else begin
              res_d.status = hffa_pkg::STAT_DONE;
            end
          end
          hffa_pkg::K_READ: begin
            res_d.form_factor = sum_rd;
            res_d.status      = hffa_pkg::STAT_DONE;
          end
          default: begin
            res_d.status = cur_q.status;
          end
        endcase
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hffa_pkg::BK_INIT;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  hffa_ram #(.Width(FacW), .Depth(TblDepth)) u_top_tbl (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (cmd_i.tbl_addr[TblAw-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (cmd_i.tbl_addr[TblAw-1:0]),
    .rdata_o (top_rd)
  );

  hffa_ram #(.Width(FacW), .Depth(TblDepth)) u_side_tbl (
    .clk_i   (clk_i),
    .we_i    (side_we),
    .waddr_i (cmd_i.tbl_addr[TblAw-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (cmd_i.tbl_addr[TblAw-1:0]),
    .rdata_o (side_rd)
  );

  hffa_ram #(.Width(SumW), .Depth(MaxElements)) u_sums (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (cmd_i.sum_addr[SumAw-1:0]),
    .rdata_o (sum_rd)
  );

endmodule

/* rtl/hemicube_form_factor_accumulate_unit.sv */
// hemicube_form_factor_accumulate_unit: top level with config registers, front, queue and back
// depends on hffa_pkg, hffa_front, hffa_fifo and hffa_back
// flow: start is taken while busy is low, queued, popped by the idle back, then executed; done_o is registered
// the back executes one word at a time (sum memory read, then add and write back);
//   a clear walks the whole sum memory before the back takes the next word
// reset: busy stays high while the sum memory is zeroed; done_o is a strobe
module hemicube_form_factor_accumulate_unit #(
  parameter int MaxHalfRes  = hffa_pkg::MAX_HALF_RES,
  parameter int MaxElements = hffa_pkg::MAX_ELEMENTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hffa_pkg::hffa_in_t  in_i,
  output logic                done_o,
  output hffa_pkg::hffa_out_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i
);

  logic [6:0]          half_res_q;
  logic                wide_ids_q;
  hffa_pkg::hffa_cmd_t dec_cmd;
  hffa_pkg::hffa_cmd_t q_cmd;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic                bk_init;
  logic                accept;

  assign busy   = q_full || bk_init;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_res_q <= hffa_pkg::HALF_RES_RESET;
      wide_ids_q <= hffa_pkg::WIDE_IDS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == hffa_pkg::CFG_HALF_RES) begin
        half_res_q <= cfg_wdata_i;
      end else begin
        wide_ids_q <= cfg_wdata_i[0];
      end
    end
  end

  hffa_front #(.MaxHalfRes(MaxHalfRes), .MaxElements(MaxElements)) u_front (
    .in_i       (in_i),
    .half_res_i (half_res_q),
    .wide_ids_i (wide_ids_q),
    .cmd_o      (dec_cmd)
  );

  hffa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (dec_cmd),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hffa_back #(.MaxHalfRes(MaxHalfRes), .MaxElements(MaxElements)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .init_o      (bk_init),
    .done_o      (done_o),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  a_no_result_during_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_init |-> !done_o) else $error("result during reset sweep");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result strobes");

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(bk_init)) else $error("reset sweep restarted");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");
`endif

endmodule

/* bench/hemicube_form_factor_accumulate_unit_tb.sv */
// hemicube_form_factor_accumulate_unit_tb: self-checking bench for the form factor accumulate unit
// drives table writes, pixels, reads and clears under random idling and config changes
// depends on rtl/hffa_pkg.sv and rtl/hemicube_form_factor_accumulate_unit.sv
module hemicube_form_factor_accumulate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hffa_pkg::*;

  localparam int TBL_DEPTH = MAX_HALF_RES * MAX_HALF_RES;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

  class form_factor_board;
    logic [SUM_W-1:0] sums [MAX_ELEMENTS];
    logic [FACTOR_FRAC_BITS-1:0] top_tbl [TBL_DEPTH];
    logic [FACTOR_FRAC_BITS-1:0] side_tbl [TBL_DEPTH];
    logic [6:0] half_res;
    logic wide_ids;
    hffa_out_t pending_results [$];
    int errors;

    function new();
      foreach (sums[i]) sums[i] = '0;
      foreach (top_tbl[i]) top_tbl[i] = '0;
      foreach (side_tbl[i]) side_tbl[i] = '0;
      half_res = HALF_RES_RESET;
      wide_ids = WIDE_IDS_RESET;
      errors = 0;
    endfunction

    function void note_cfg(logic idx, logic [6:0] val);
      if (idx == CFG_HALF_RES) half_res = val;
      else wide_ids = val[0];
    endfunction

    function hffa_out_t predict_form_factor(hffa_in_t w);
      hffa_out_t r;
      int h;
      int tr;
      int tc;
      int idx;
      logic [ID_W-1:0] bg;
      logic [FACTOR_FRAC_BITS-1:0] f;
      logic [SUM_W:0] total;
      r.form_factor = '0;
      r.status = STAT_DONE;
      case (w.opcode)
        OP_CLEAR: foreach (sums[i]) sums[i] = '0;
        OP_WR_TOP, OP_WR_SIDE: begin
          if (w.row >= MAX_HALF_RES || w.col >= MAX_HALF_RES) begin
            r.status = STAT_RANGE;
          end else begin
            idx = w.row * MAX_HALF_RES + w.col;
            if (w.opcode == OP_WR_TOP) top_tbl[idx] = w.factor_value;
            else side_tbl[idx] = w.factor_value;
          end
        end
        OP_ACCUM: begin
          h = (half_res == 0) ? 1 : (half_res > MAX_HALF_RES) ? MAX_HALF_RES : half_res;
          bg = wide_ids ? BG_WIDE : BG_NARROW;
          if (w.row >= 2 * h || w.col >= 2 * h) begin
            r.status = STAT_RANGE;
          end else if (w.face_kind && w.row < h) begin
            r.status = STAT_IGNORED;
          end else if (w.item_id == bg) begin
            r.status = STAT_IGNORED;
          end else if (w.item_id >= MAX_ELEMENTS) begin
            r.status = STAT_RANGE;
          end else begin
            tr = (w.row < h) ? w.row : 2 * h - 1 - w.row;
            tc = (w.col < h) ? w.col : 2 * h - 1 - w.col;
            idx = tr * MAX_HALF_RES + tc;
            f = w.face_kind ? side_tbl[idx] : top_tbl[idx];
            total = {1'b0, sums[w.item_id]} + {3'b000, f};
            if (total > {1'b0, {SUM_W{1'b1}}}) begin
              sums[w.item_id] = {SUM_W{1'b1}};
              r.status = STAT_SAT;
            end else begin
              sums[w.item_id] = total[SUM_W-1:0];
            end
          end
        end
        OP_READ: begin
          if (w.item_id >= MAX_ELEMENTS) r.status = STAT_RANGE;
          else r.form_factor = sums[w.item_id];
        end
        default: r.status = STAT_IGNORED;
      endcase
      return r;
    endfunction

    function void note_word(hffa_in_t w);
      pending_results.push_back(predict_form_factor(w));
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(hffa_out_t got);
      hffa_out_t exp_word;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word ff=%h status=%0d", got.form_factor, got.status));
      end else begin
        exp_word = pending_results.pop_front();
        if (got.form_factor !== exp_word.form_factor)
          report($sformatf("form_factor got %h want %h", got.form_factor, exp_word.form_factor));
        if (got.status !== exp_word.status)
          report($sformatf("status got %0d want %0d", got.status, exp_word.status));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  hffa_in_t in_i = '0;
  logic done_o;
  hffa_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_HALF_RES;
  logic [6:0] cfg_wdata_i = '0;

  form_factor_board board;
  int cycles = 0;
  logic [6:0] half_set = HALF_RES_RESET;
  logic wide_set = WIDE_IDS_RESET;
  bit top_seen [TBL_DEPTH];
  bit side_seen [TBL_DEPTH];
  int top_list [$];
  int side_list [$];

  hemicube_form_factor_accumulate_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_word(result_o);
  end

  function automatic int cur_h();
    if (half_set == 0) return 1;
    if (half_set > MAX_HALF_RES) return MAX_HALF_RES;
    return half_set;
  endfunction

  function automatic hffa_in_t mk_word(logic [2:0] op, int row, int col, bit face, int id,
                                       logic [31:0] val);
    hffa_in_t w;
    w.opcode = op;
    w.row = 7'(row);
    w.col = 7'(col);
    w.face_kind = face;
    w.item_id = ID_W'(id);
    w.factor_value = val;
    return w;
  endfunction

  task automatic issue(input hffa_in_t w, input int idle_pct);
    int slot;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    if ((w.opcode == OP_WR_TOP || w.opcode == OP_WR_SIDE) &&
        w.row < MAX_HALF_RES && w.col < MAX_HALF_RES) begin
      slot = w.row * MAX_HALF_RES + w.col;
      if (w.opcode == OP_WR_TOP && !top_seen[slot]) begin
        top_seen[slot] = 1'b1;
        top_list.push_back(slot);
      end
      if (w.opcode == OP_WR_SIDE && !side_seen[slot]) begin
        side_seen[slot] = 1'b1;
        side_list.push_back(slot);
      end
    end
    start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [6:0] half_val, input logic wide_val);
    logic [6:0] wide_word;
    wide_word = {6'($urandom()), wide_val};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_HALF_RES;
    cfg_wdata_i <= half_val;
    @(posedge clk_i);
    board.note_cfg(CFG_HALF_RES, half_val);
    half_set = half_val;
    cfg_idx_i <= CFG_WIDE_IDS;
    cfg_wdata_i <= wide_word;
    @(posedge clk_i);
    board.note_cfg(CFG_WIDE_IDS, wide_word);
    wide_set = wide_val;
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_entry(input bit side, input int h, output int tr, output int tc,
                            output bit found);
    int hits [$];
    int slot;
    if (side) begin
      foreach (side_list[i])
        if (side_list[i] / MAX_HALF_RES < h && side_list[i] % MAX_HALF_RES < h)
          hits.push_back(side_list[i]);
    end else begin
      foreach (top_list[i])
        if (top_list[i] / MAX_HALF_RES < h && top_list[i] % MAX_HALF_RES < h)
          hits.push_back(top_list[i]);
    end
    found = hits.size() > 0;
    tr = 0;
    tc = 0;
    if (found) begin
      slot = hits[$urandom_range(0, hits.size() - 1)];
      tr = slot / MAX_HALF_RES;
      tc = slot % MAX_HALF_RES;
    end
  endtask

  task automatic make_table_write(inout hffa_in_t w, input bit side, input int h);
    int slot;
    w.opcode = side ? OP_WR_SIDE : OP_WR_TOP;
    slot = $urandom_range(0, 19);
    if (slot < 17) begin
      w.row = 7'($urandom_range(0, h - 1));
      w.col = 7'($urandom_range(0, h - 1));
    end else if (slot < 19) begin
      w.row = 7'($urandom_range(0, MAX_HALF_RES - 1));
      w.col = 7'($urandom_range(0, MAX_HALF_RES - 1));
    end
    if ($urandom_range(0, 2) == 0) w.factor_value[31:28] = '1;
  endtask

  task automatic make_random_word(output hffa_in_t w);
    int pick;
    int h;
    int tr;
    int tc;
    bit found;
    h = cur_h();
    w = mk_word(OP_ACCUM, $urandom_range(0, 127), $urandom_range(0, 127),
                1'($urandom_range(0, 1)), $urandom_range(0, 24'hFFFFFF), $urandom());
    pick = $urandom_range(0, 999);
    if (pick < 8) begin
      w.opcode = OP_CLEAR;
    end else if (pick < 38) begin
      w.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else if (pick < 238) begin
      w.opcode = OP_READ;
      pick = $urandom_range(0, 9);
      if (pick < 8) w.item_id = ID_W'($urandom_range(0, 15));
      else if (pick == 8) w.item_id = ID_W'($urandom_range(0, MAX_ELEMENTS - 1));
    end else if (pick < 418) begin
      make_table_write(w, 1'($urandom_range(0, 1)), h);
    end else begin
      pick_entry(w.face_kind, h, tr, tc, found);
      if (!found) begin
        make_table_write(w, w.face_kind, h);
      end else begin
        w.row = 7'((w.face_kind || $urandom_range(0, 1)) ? 2 * h - 1 - tr : tr);
        w.col = 7'($urandom_range(0, 1) ? 2 * h - 1 - tc : tc);
        w.item_id = ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(0, 15)) :
                                                  ID_W'($urandom_range(0, MAX_ELEMENTS - 1));
        case ($urandom_range(0, 14))
          0: w.item_id = wide_set ? BG_WIDE : BG_NARROW;
          1: w.item_id = wide_set ? BG_NARROW : BG_WIDE;
          2: w.item_id = ID_W'($urandom_range(MAX_ELEMENTS, 24'hFFFFFF));
          3: begin
            w.face_kind = 1'b1;
            w.row = 7'($urandom_range(0, h - 1));
          end
          4: begin
            if (h < MAX_HALF_RES) begin
              if ($urandom_range(0, 1)) w.row = 7'($urandom_range(2 * h, 127));
              else w.col = 7'($urandom_range(2 * h, 127));
            end
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic run_directed();
    issue(mk_word(OP_READ, 0, 0, 0, 0, 0), 20);
    issue(mk_word(OP_WR_TOP, 0, 0, 0, 0, 32'hFFFF_FFFF), 20);
    issue(mk_word(OP_WR_TOP, 31, 31, 0, 0, 32'h0000_0001), 20);
    issue(mk_word(OP_WR_SIDE, 0, 0, 1, 0, 32'h8000_0000), 20);
    issue(mk_word(OP_WR_SIDE, 63, 63, 1, 0, 32'h0000_0000), 20);
    issue(mk_word(OP_WR_TOP, 64, 0, 0, 0, 32'h1234_5678), 20);
    issue(mk_word(OP_WR_SIDE, 0, 127, 1, 0, 32'h1234_5678), 20);
    for (int k = 0; k < 5; k++)
      issue(mk_word(OP_ACCUM, k[0] ? 63 : 0, k[1] ? 63 : 0, 0, 0, 0), 20);
    issue(mk_word(OP_READ, 0, 0, 0, 0, 0), 20);
    issue(mk_word(OP_ACCUM, 31, 32, 0, 1, 0), 20);
    issue(mk_word(OP_ACCUM, 63, 0, 1, MAX_ELEMENTS - 1, 0), 20);
    issue(mk_word(OP_ACCUM, 0, 0, 1, 2, 0), 20);
    issue(mk_word(OP_ACCUM, 64, 0, 0, 2, 0), 20);
    issue(mk_word(OP_ACCUM, 0, 127, 0, 2, 0), 20);
    issue(mk_word(OP_ACCUM, 0, 0, 0, BG_WIDE, 0), 20);
    issue(mk_word(OP_ACCUM, 0, 0, 0, BG_NARROW, 0), 20);
    issue(mk_word(OP_ACCUM, 0, 0, 0, MAX_ELEMENTS, 0), 20);
    issue(mk_word(OP_READ, 0, 0, 0, MAX_ELEMENTS - 1, 0), 20);
    issue(mk_word(OP_READ, 0, 0, 0, MAX_ELEMENTS, 0), 20);
    issue(mk_word(OP_READ, 0, 0, 0, BG_WIDE, 0), 20);
    issue(mk_word(OP_FIRST_UNUSED, 0, 0, 0, 0, 0), 20);
    issue(mk_word(OP_LAST_UNUSED, 0, 0, 0, 0, 0), 20);
    issue(mk_word(OP_CLEAR, 0, 0, 0, 0, 0), 20);
    issue(mk_word(OP_READ, 0, 0, 0, 0, 0), 20);
  endtask

  initial begin
    hffa_in_t w;
    logic [6:0] half_plan [6];
    logic wide_plan [6];
    int idle_plan [6];
    board = new();
    half_plan = '{7'd1, 7'd0, 7'd127, 7'd64, 7'($urandom_range(0, 127)), 7'd32};
    wide_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1};
    idle_plan = '{50, 30, 15, 40, 25, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < 6; p++) begin
      drain();
      set_config(half_plan[p], wide_plan[p]);
      for (int n = 0; n < 240; n++) begin
        make_random_word(w);
        issue(w, idle_plan[p]);
      end
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hffa_pkg.sv
rtl/hffa_ram.sv
rtl/hffa_front.sv
rtl/hffa_fifo.sv
rtl/hffa_back.sv
rtl/hemicube_form_factor_accumulate_unit.sv
bench/hemicube_form_factor_accumulate_unit_tb.sv
